// File: rtl/core/source_tokenizer_assert.svh
// Assertion macros for the source tokeniser.
// Used by source_tokenizer.sv; expects i_clk and i_rst_n in scope.
`ifndef SOURCE_TOKENIZER_ASSERT_SVH
`define SOURCE_TOKENIZER_ASSERT_SVH

// same-cycle implication
`define ST_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("source_tokenizer assertion failed");

// next-cycle implication
`define ST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("source_tokenizer assertion failed");

`endif

// File: rtl/core/srctok_pkg.sv
// Package for the source tokeniser: token kinds, scan modes, character codes,
// result types and keyword lookup. No dependencies.
`timescale 1ns / 1ps
package srctok_pkg;

    localparam int MaxSourceBytes = 65536;
    localparam int PosW           = $clog2(MaxSourceBytes) + 1;
    localparam int KeywordChars   = 6;
    localparam int WlenW          = $clog2(KeywordChars + 2);
    localparam int NumKeywords    = 14;
    localparam int QDepth         = 4;

    localparam logic [5:0] K_NOT = 6'd11, K_AND = 6'd12, K_OR = 6'd13, K_EOF = 6'd14;
    localparam logic [5:0] K_LPAREN = 6'd15, K_RPAREN = 6'd16, K_LBRACE = 6'd17;
    localparam logic [5:0] K_RBRACE = 6'd18, K_COLON = 6'd19, K_SEMI = 6'd20;
    localparam logic [5:0] K_COMMA = 6'd21, K_EQEQ = 6'd22, K_EQ = 6'd23;
    localparam logic [5:0] K_PLUSEQ = 6'd24, K_PLUS = 6'd25, K_MINUSEQ = 6'd26;
    localparam logic [5:0] K_ARROW = 6'd27, K_MINUS = 6'd28, K_STAREQ = 6'd29;
    localparam logic [5:0] K_STAR = 6'd30, K_SLASHEQ = 6'd31, K_SLASH = 6'd32;
    localparam logic [5:0] K_RANGE = 6'd33, K_PCTEQ = 6'd34, K_PCT = 6'd35;
    localparam logic [5:0] K_GE = 6'd36, K_SHREQ = 6'd37, K_SHR = 6'd38, K_GT = 6'd39;
    localparam logic [5:0] K_LE = 6'd40, K_SHLEQ = 6'd41, K_SHL = 6'd42, K_LT = 6'd43;
    localparam logic [5:0] K_NE = 6'd44, K_AMPEQ = 6'd45, K_AMP = 6'd46;
    localparam logic [5:0] K_PIPEEQ = 6'd47, K_PIPE = 6'd48, K_CARETEQ = 6'd49;
    localparam logic [5:0] K_CARET = 6'd50, K_TILDEEQ = 6'd51, K_TILDE = 6'd52;
    localparam logic [5:0] K_STRING = 6'd53, K_IDENT = 6'd54, K_NUMBER = 6'd55;
    localparam logic [5:0] K_ERRKIND = 6'd0;

    localparam logic [1:0] E_NONE = 2'd0, E_UNEXP = 2'd1, E_UNTERM = 2'd2;

    localparam logic [7:0] C_TAB = 8'h09, C_NL = 8'h0A, C_CR = 8'h0D, C_SP = 8'h20;
    localparam logic [7:0] C_BANG = 8'h21, C_QUOTE = 8'h22, C_PCT = 8'h25, C_AMP = 8'h26;
    localparam logic [7:0] C_LPAREN = 8'h28, C_RPAREN = 8'h29, C_STAR = 8'h2A;
    localparam logic [7:0] C_PLUS = 8'h2B, C_COMMA = 8'h2C, C_MINUS = 8'h2D;
    localparam logic [7:0] C_DOT = 8'h2E, C_SLASH = 8'h2F, C_COLON = 8'h3A;
    localparam logic [7:0] C_SEMI = 8'h3B, C_LT = 8'h3C, C_EQ = 8'h3D, C_GT = 8'h3E;
    localparam logic [7:0] C_CARET = 8'h5E, C_USCORE = 8'h5F, C_LBRACE = 8'h7B;
    localparam logic [7:0] C_PIPE = 8'h7C, C_RBRACE = 8'h7D, C_TILDE = 8'h7E;

    typedef enum logic [4:0] {
        M_IDLE, M_EQ, M_PLUS, M_MINUS, M_STAR, M_SLASH, M_DOT, M_PCT, M_GT,
        M_GTGT, M_LT, M_LTLT, M_BANG, M_AMP, M_PIPE, M_CARET, M_TILDE,
        M_COMMENT, M_STR, M_IDENT, M_NUM, M_NUMDOT, M_FRAC, M_SUFFIX
    } t_mode;

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
        logic [1:0]  err;
        logic        last;
    } t_result;

    typedef struct packed {
        logic            emit;
        logic [5:0]      kind;
        logic [15:0]     start;
        logic [PosW-1:0] len;
        logic [1:0]      err;
        logic            call;
        t_mode           mode;
        logic            halt;
    } t_pout;

    typedef logic [KeywordChars-1:0][7:0] t_word;

    localparam t_word KW_TEXT [NumKeywords] = '{
        {8'h00, 8'h00, "n", "f", "e", "d"}, {8'h00, 8'h00, 8'h00, "t", "e", "l"},
        {8'h00, 8'h00, 8'h00, 8'h00, "s", "a"}, {"n", "r", "u", "t", "e", "r"},
        {8'h00, 8'h00, 8'h00, 8'h00, "n", "i"}, {8'h00, 8'h00, 8'h00, "r", "o", "f"},
        {8'h00, 8'h00, 8'h00, 8'h00, "f", "i"}, {8'h00, 8'h00, "e", "s", "l", "e"},
        {8'h00, "e", "l", "i", "h", "w"}, {8'h00, 8'h00, "e", "u", "r", "t"},
        {8'h00, "e", "s", "l", "a", "f"}, {8'h00, 8'h00, 8'h00, "t", "o", "n"},
        {8'h00, 8'h00, 8'h00, "d", "n", "a"}, {8'h00, 8'h00, 8'h00, 8'h00, "r", "o"}
    };
    localparam logic [WlenW-1:0] KW_LEN [NumKeywords] = '{
        3'd4, 3'd3, 3'd2, 3'd6, 3'd2, 3'd3, 3'd2, 3'd4, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2
    };

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [5:0] word_kind(input t_word buf_w, input logic [WlenW-1:0] len);
        logic [5:0] k;
        logic       hit;
        k = K_IDENT;
        for (int i = NumKeywords - 1; i >= 0; i--) begin
            hit = (len == KW_LEN[i]);
            for (int j = 0; j < KeywordChars; j++) begin
                if (j < int'(KW_LEN[i]) && buf_w[j] != KW_TEXT[i][j]) hit = 1'b0;
            end
            if (hit) k = 6'(i);
        end
        return k;
    endfunction

    // two-char operator pending: '=' completes it, anything else flushes the single
    function automatic t_pout pair_out(input logic [7:0] c, input logic [5:0] k2,
                                       input logic [5:0] k1, input logic [15:0] start);
        t_pout o;
        o       = '0;
        o.emit  = 1'b1;
        o.start = start;
        o.mode  = M_IDLE;
        if (c == C_EQ) begin
            o.kind = k2;
            o.len  = PosW'(2);
        end else begin
            o.kind = k1;
            o.len  = PosW'(1);
            o.call = 1'b1;
        end
        return o;
    endfunction

endpackage

// File: rtl/core/source_tokenizer.sv
// Output: a token is pushed into the result queue when the character that completes it is accepted.
// Throughput: one input word per cycle while results are taken; an item yields up to two
// results, drained one per cycle from a four-entry result queue that gates o_s_tready.
// Reset: synchronous active-low i_rst_n clears scan state, line to one, empties the queue.
// Depends on srctok_pkg and source_tokenizer_assert.svh.
`timescale 1ns / 1ps
`include "source_tokenizer_assert.svh"
module source_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] ch
    input  logic        i_s_tuser,   // [0] kind (end marker)
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // kind[5:0] start[21:6] length[37:22] line[53:38] err[55:54]
    output logic        o_m_tlast
);
    import srctok_pkg::*;

    localparam int QW = $clog2(QDepth);

    t_mode              r_mode, n_mode;
    logic [15:0]        r_start, n_start;
    logic [PosW-1:0]    r_pos, n_pos;
    logic [15:0]        r_line, n_line;
    t_word              r_word, n_word;
    logic [WlenW-1:0]   r_wlen, n_wlen;
    logic               r_halt, n_halt;

    t_result            r_q [QDepth];
    logic [QW-1:0]      r_wr, r_rd;
    logic [QW:0]        r_count;

    logic               acc, pop, push0, push1;
    t_result            res0, res1;
    logic [7:0]         c;
    logic [15:0]        p;
    logic [PosW-1:0]    len17;

    // idle-entry decode
    logic               id_emit, id_halt, id_nl, id_word;
    logic [5:0]         id_kind;
    logic [1:0]         id_err;
    t_mode              id_mode;

    t_pout              po, fl;
    logic               range2;

    assign c     = i_s_tdata;
    assign p     = r_pos[15:0];
    assign len17 = r_pos - {1'b0, r_start};
    assign acc   = i_s_tvalid && o_s_tready;
    assign pop   = o_m_tvalid && i_m_tready;

    assign o_s_tready = (r_count <= (QW+1)'(QDepth - 2));
    assign o_m_tvalid = (r_count != '0);
    assign o_m_tdata  = {r_q[r_rd].err, r_q[r_rd].line, r_q[r_rd].len,
                         r_q[r_rd].start, r_q[r_rd].kind};
    assign o_m_tlast  = r_q[r_rd].last;

    function automatic logic [15:0] sat(input logic [PosW-1:0] v);
        return (v > PosW'(16'hFFFF)) ? 16'hFFFF : v[15:0];
    endfunction

    always_comb begin
        id_emit = 1'b0;
        id_halt = 1'b0;
        id_nl   = 1'b0;
        id_word = 1'b0;
        id_kind = K_ERRKIND;
        id_err  = E_NONE;
        id_mode = M_IDLE;
        case (c)
            C_LPAREN: begin id_emit = 1'b1; id_kind = K_LPAREN; end
            C_RPAREN: begin id_emit = 1'b1; id_kind = K_RPAREN; end
            C_LBRACE: begin id_emit = 1'b1; id_kind = K_LBRACE; end
            C_RBRACE: begin id_emit = 1'b1; id_kind = K_RBRACE; end
            C_COLON:  begin id_emit = 1'b1; id_kind = K_COLON; end
            C_SEMI:   begin id_emit = 1'b1; id_kind = K_SEMI; end
            C_COMMA:  begin id_emit = 1'b1; id_kind = K_COMMA; end
            C_EQ:     id_mode = M_EQ;
            C_PLUS:   id_mode = M_PLUS;
            C_MINUS:  id_mode = M_MINUS;
            C_STAR:   id_mode = M_STAR;
            C_SLASH:  id_mode = M_SLASH;
            C_DOT:    id_mode = M_DOT;
            C_PCT:    id_mode = M_PCT;
            C_GT:     id_mode = M_GT;
            C_LT:     id_mode = M_LT;
            C_BANG:   id_mode = M_BANG;
            C_AMP:    id_mode = M_AMP;
            C_PIPE:   id_mode = M_PIPE;
            C_CARET:  id_mode = M_CARET;
            C_TILDE:  id_mode = M_TILDE;
            C_QUOTE:  id_mode = M_STR;
            C_SP, C_TAB, C_CR: id_mode = M_IDLE;
            C_NL:     id_nl = 1'b1;
            default: begin
                if (is_alpha(c)) begin
                    id_word = 1'b1;
                    id_mode = M_IDENT;
                end else if (is_digit(c)) begin
                    id_mode = M_NUM;
                end else begin
                    id_emit = 1'b1;
                    id_err  = E_UNEXP;
                    id_halt = 1'b1;
                end
            end
        endcase
    end

    always_comb begin
        po       = '0;
        po.start = r_start;
        po.mode  = r_mode;
        range2   = 1'b0;
        unique case (r_mode)
            M_IDLE:  po.call = 1'b1;
            M_EQ:    po = pair_out(c, K_EQEQ, K_EQ, r_start);
            M_PLUS:  po = pair_out(c, K_PLUSEQ, K_PLUS, r_start);
            M_STAR:  po = pair_out(c, K_STAREQ, K_STAR, r_start);
            M_PCT:   po = pair_out(c, K_PCTEQ, K_PCT, r_start);
            M_BANG:  po = pair_out(c, K_NE, K_NOT, r_start);
            M_CARET: po = pair_out(c, K_CARETEQ, K_CARET, r_start);
            M_TILDE: po = pair_out(c, K_TILDEEQ, K_TILDE, r_start);
            M_MINUS: begin
                po = pair_out(c, K_MINUSEQ, K_MINUS, r_start);
                if (c == C_GT) begin po.kind = K_ARROW; po.len = PosW'(2); po.call = 1'b0; end
            end
            M_SLASH: begin
                if (c == C_SLASH) po.mode = M_COMMENT;
                else po = pair_out(c, K_SLASHEQ, K_SLASH, r_start);
            end
            M_AMP: begin
                po = pair_out(c, K_AMPEQ, K_AMP, r_start);
                if (c == C_AMP) begin po.kind = K_AND; po.len = PosW'(2); po.call = 1'b0; end
            end
            M_PIPE: begin
                po = pair_out(c, K_PIPEEQ, K_PIPE, r_start);
                if (c == C_PIPE) begin po.kind = K_OR; po.len = PosW'(2); po.call = 1'b0; end
            end
            M_GT: begin
                if (c == C_GT) po.mode = M_GTGT;
                else po = pair_out(c, K_GE, K_GT, r_start);
            end
            M_LT: begin
                if (c == C_LT) po.mode = M_LTLT;
                else po = pair_out(c, K_LE, K_LT, r_start);
            end
            M_GTGT, M_LTLT: begin
                po.emit = 1'b1;
                po.mode = M_IDLE;
                po.kind = (r_mode == M_GTGT) ? K_SHR : K_SHL;
                po.len  = PosW'(2);
                po.call = 1'b1;
                if (c == C_EQ) begin
                    po.kind = (r_mode == M_GTGT) ? K_SHREQ : K_SHLEQ;
                    po.len  = PosW'(3);
                    po.call = 1'b0;
                end
            end
            M_DOT: begin
                if (c == C_DOT) begin
                    po.emit = 1'b1;
                    po.kind = K_RANGE;
                    po.len  = PosW'(2);
                    po.mode = M_IDLE;
                end else begin
                    po.call = 1'b1;
                end
            end
            M_COMMENT: po.call = (c == C_NL);
            M_STR: begin
                po.start = r_start + 16'd1;
                po.len   = len17 - PosW'(1);
                if (c == C_QUOTE) begin
                    po.emit = 1'b1;
                    po.kind = K_STRING;
                    po.mode = M_IDLE;
                end else if (c == C_NL) begin
                    po.emit = 1'b1;
                    po.kind = K_ERRKIND;
                    po.err  = E_UNTERM;
                    po.halt = 1'b1;
                end
            end
            M_IDENT: begin
                if (!(is_alpha(c) || is_digit(c) || c == C_USCORE)) begin
                    po.emit = 1'b1;
                    po.kind = word_kind(r_word, r_wlen);
                    po.len  = len17;
                    po.call = 1'b1;
                end
            end
            M_NUM: begin
                if (c == C_DOT) po.mode = M_NUMDOT;
                else if (is_alpha(c)) po.mode = M_SUFFIX;
                else if (!(is_digit(c) || c == C_USCORE)) begin
                    po.emit = 1'b1;
                    po.kind = K_NUMBER;
                    po.len  = len17;
                    po.call = 1'b1;
                end
            end
            M_NUMDOT: begin
                if (is_digit(c)) po.mode = M_FRAC;
                else begin
                    po.emit = 1'b1;
                    po.kind = K_NUMBER;
                    po.len  = len17 - PosW'(1);
                    po.mode = M_IDLE;
                    range2  = (c == C_DOT);
                    po.call = !range2;
                end
            end
            M_FRAC, M_SUFFIX: begin
                if (is_alpha(c)) po.mode = M_SUFFIX;
                else if (!is_digit(c)) begin
                    po.emit = 1'b1;
                    po.kind = K_NUMBER;
                    po.len  = len17;
                    po.call = 1'b1;
                end
            end
            default: po.call = 1'b1;
        endcase
    end

    // pending token at end of source
    always_comb begin
        fl       = '0;
        fl.start = r_start;
        fl.emit  = !r_halt;
        fl.len   = PosW'(1);
        unique case (r_mode)
            M_EQ:    fl.kind = K_EQ;
            M_PLUS:  fl.kind = K_PLUS;
            M_MINUS: fl.kind = K_MINUS;
            M_STAR:  fl.kind = K_STAR;
            M_SLASH: fl.kind = K_SLASH;
            M_PCT:   fl.kind = K_PCT;
            M_GT:    fl.kind = K_GT;
            M_LT:    fl.kind = K_LT;
            M_BANG:  fl.kind = K_NOT;
            M_AMP:   fl.kind = K_AMP;
            M_PIPE:  fl.kind = K_PIPE;
            M_CARET: fl.kind = K_CARET;
            M_TILDE: fl.kind = K_TILDE;
            M_GTGT:  begin fl.kind = K_SHR; fl.len = PosW'(2); end
            M_LTLT:  begin fl.kind = K_SHL; fl.len = PosW'(2); end
            M_STR: begin
                fl.kind  = K_ERRKIND;
                fl.err   = E_UNTERM;
                fl.start = r_start + 16'd1;
                fl.len   = len17 - PosW'(1);
            end
            M_IDENT: begin fl.kind = word_kind(r_word, r_wlen); fl.len = len17; end
            M_NUM, M_FRAC, M_SUFFIX: begin fl.kind = K_NUMBER; fl.len = len17; end
            M_NUMDOT: begin fl.kind = K_NUMBER; fl.len = len17 - PosW'(1); end
            default: fl.emit = 1'b0;
        endcase
    end

    always_comb begin
        n_mode  = r_mode;
        n_start = r_start;
        n_pos   = r_pos;
        n_line  = r_line;
        n_word  = r_word;
        n_wlen  = r_wlen;
        n_halt  = r_halt;
        push0   = 1'b0;
        push1   = 1'b0;
        res0    = '0;
        res1    = '0;
        res0.line = r_line;
        res1.line = r_line;
        if (acc && i_s_tuser) begin
            res1.kind  = K_EOF;
            res1.start = p;
            res1.len   = 16'd0;
            res1.last  = 1'b1;
            if (fl.emit) begin
                res0.kind  = fl.kind;
                res0.start = fl.start;
                res0.len   = sat(fl.len);
                res0.err   = fl.err;
                push0 = 1'b1;
                push1 = 1'b1;
            end else begin
                res0  = res1;
                push0 = 1'b1;
            end
            n_mode  = M_IDLE;
            n_start = '0;
            n_pos   = '0;
            n_line  = 16'd1;
            n_wlen  = '0;
            n_halt  = 1'b0;
        end else if (acc && !r_halt && !r_pos[PosW-1]) begin
            n_pos = r_pos + PosW'(1);
            if (po.emit) begin
                res0.kind  = po.kind;
                res0.start = po.start;
                res0.len   = sat(po.len);
                res0.err   = po.err;
                push0 = 1'b1;
                if (range2) begin
                    res1.kind  = K_RANGE;
                    res1.start = p - 16'd1;
                    res1.len   = 16'd2;
                    push1 = 1'b1;
                end else if (po.call && id_emit) begin
                    res1.kind  = id_kind;
                    res1.start = p;
                    res1.len   = 16'd1;
                    res1.err   = id_err;
                    push1 = 1'b1;
                end
            end else if (po.call && id_emit) begin
                res0.kind  = id_kind;
                res0.start = p;
                res0.len   = 16'd1;
                res0.err   = id_err;
                push0 = 1'b1;
            end
            if (push1) res1.last = 1'b1;
            else res0.last = 1'b1;
            n_halt = po.halt || (po.call && id_halt);
            if (po.call) begin
                n_mode  = id_mode;
                n_start = p;
                if (id_nl && r_line != 16'hFFFF) n_line = r_line + 16'd1;
                if (id_word) begin
                    n_word[0] = c;
                    n_wlen    = WlenW'(1);
                end
            end else begin
                n_mode = po.mode;
                if (r_mode == M_IDENT) begin
                    if (r_wlen < WlenW'(KeywordChars)) n_word[r_wlen[$clog2(KeywordChars)-1:0]] = c;
                    if (r_wlen <= WlenW'(KeywordChars)) n_wlen = r_wlen + WlenW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_start <= '0;
            r_pos   <= '0;
            r_line  <= 16'd1;
            r_wlen  <= '0;
            r_halt  <= 1'b0;
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_pos   <= n_pos;
            r_line  <= n_line;
            r_wlen  <= n_wlen;
            r_halt  <= n_halt;
            r_wr    <= r_wr + QW'(push0) + QW'(push1);
            if (pop) r_rd <= r_rd + QW'(1);
            r_count <= r_count + (QW+1)'(push0) + (QW+1)'(push1) - (QW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        if (push0) r_q[r_wr] <= res0;
        if (push1) r_q[r_wr + QW'(1)] <= res1;
    end

    `ST_ASSERT_IMPL(a_queue_bound, 1'b1, r_count <= (QW+1)'(QDepth))
    `ST_ASSERT_IMPL(a_line_nonzero, 1'b1, r_line != 16'd0)
    `ST_ASSERT_NEXT(a_end_resets, acc && i_s_tuser, r_mode == M_IDLE && !r_halt && r_pos == '0)
    `ST_ASSERT_NEXT(a_halt_quiet, acc && !i_s_tuser && r_halt, r_count <= $past(r_count))

endmodule
